### rtl/mono_to_three_pixel_packer_defines.svh
// Assertion macros for the packer; clk and arst_n must be in scope.
`ifndef MONO_TO_THREE_PIXEL_PACKER_DEFINES_SVH
`define MONO_TO_THREE_PIXEL_PACKER_DEFINES_SVH

// Same-cycle implication.
`define MTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mtp_pkg.sv
package mtp_pkg;

	localparam logic [5:0] MAX_LINE_BYTES = 6'd32;

	localparam logic [7:0] MASK_FIRST  = 8'hE0;
	localparam logic [7:0] MASK_SECOND = 8'h1C;
	localparam logic [7:0] MASK_THIRD  = 8'h03;

	localparam logic [5:0] RST_LINE_BYTES = 6'd24;
	localparam logic [6:0] RST_OUT_BYTES  = 7'd60;
	localparam logic [7:0] RST_ROWS       = 8'd128;

	typedef enum logic [1:0] {
		REG_LINE_BYTES = 2'd0,
		REG_OUT_BYTES  = 2'd1,
		REG_ROWS       = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] line_bytes;
		logic [6:0] out_bytes_per_row;
		logic [7:0] rows_per_frame;
	} cfg_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [3:0]      row_end;
		logic [3:0]      frame_end;
		logic [2:0]      cnt;
	} burst_t;

endpackage

### rtl/mtp_regs.sv
module mtp_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output mtp_pkg::cfg_t cfg
);
	import mtp_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_bytes        <= RST_LINE_BYTES;
			cfg_q.out_bytes_per_row <= RST_OUT_BYTES;
			cfg_q.rows_per_frame    <= RST_ROWS;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_LINE_BYTES: cfg_q.line_bytes        <= pwdata[5:0];
				REG_OUT_BYTES:  cfg_q.out_bytes_per_row <= pwdata[6:0];
				REG_ROWS:       cfg_q.rows_per_frame    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_LINE_BYTES: prdata = {26'd0, cfg_q.line_bytes};
			REG_OUT_BYTES:  prdata = {25'd0, cfg_q.out_bytes_per_row};
			REG_ROWS:       prdata = {24'd0, cfg_q.rows_per_frame};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

### rtl/mtp_pack.sv
module mtp_pack (
	input  logic            clk,
	input  logic            arst_n,
	input  mtp_pkg::cfg_t   cfg,
	input  logic            fb_valid,
	output logic            fb_stall,
	input  logic [7:0]      fb_byte,
	input  logic            burst_free,
	output logic            ld_valid,
	output mtp_pkg::burst_t ld_data
);
	import mtp_pkg::*;

	logic            valid_s1;
	logic [7:0]      fb_byte_s1;
	logic [1:0]      phase_q;
	logic [7:0]      partial_q;
	logic [5:0]      in_col_q;
	logic [6:0]      out_col_q;
	logic [7:0]      row_count_q;

	logic [5:0]      eff_lb;
	logic            row_last;
	logic            frame_row;
	logic [11:0]     ext;
	logic [2:0]      full;
	logic [1:0]      endph;
	logic [3:0][7:0] cand;
	logic            flush;
	logic [2:0]      nc;
	logic [6:0]      room;
	logic [2:0]      m;
	logic [7:0]      partial_nx;
	logic [6:0]      out_col_nx;
	logic            adv;
	burst_t          res;

	always_comb begin
		eff_lb    = (cfg.line_bytes > MAX_LINE_BYTES) ? MAX_LINE_BYTES : cfg.line_bytes;
		row_last  = ({1'b0, in_col_q} + 7'd1) >= {1'b0, eff_lb};
		frame_row = ({1'b0, row_count_q} + 9'd1) >= {1'b0, cfg.rows_per_frame};

		case (phase_q)
			2'd1: begin
				ext   = {3'b000, fb_byte_s1, 1'b0};
				full  = 3'd3;
				endph = 2'd0;
			end
			2'd2: begin
				ext   = {2'b00, fb_byte_s1, 2'b00};
				full  = 3'd3;
				endph = 2'd1;
			end
			default: begin
				ext   = {4'b0000, fb_byte_s1};
				full  = 3'd2;
				endph = 2'd2;
			end
		endcase

		for (int k = 0; k < 4; k++) begin
			cand[k] = ({8{ext[3*k]}} & MASK_FIRST)
				| ({8{ext[3*k+1]}} & MASK_SECOND)
				| ({8{ext[3*k+2]}} & MASK_THIRD);
		end
		cand[0] = cand[0] | partial_q;

		flush = row_last && (endph != 2'd0);
		nc    = full + {2'b00, flush};
		room  = (out_col_q >= cfg.out_bytes_per_row) ? 7'd0
			: cfg.out_bytes_per_row - out_col_q;
		m     = (room < {4'd0, nc}) ? room[2:0] : nc;

		res.cnt = m;
		for (int i = 0; i < 4; i++) begin
			res.bytes[i]     = cand[i];
			res.row_end[i]   = (3'(i) < m)
				&& ((({1'b0, out_col_q} + 8'(i + 1)) == {1'b0, cfg.out_bytes_per_row})
				|| (row_last && (3'(i) == m - 3'd1)));
			res.frame_end[i] = res.row_end[i] && frame_row;
		end

		partial_nx = (row_last || (endph == 2'd0)) ? 8'd0 : cand[full[1:0]];
		out_col_nx = row_last ? 7'd0 : out_col_q + {4'd0, m};
	end

	assign adv      = valid_s1 && ((m == 3'd0) || burst_free);
	assign ld_valid = adv && (m != 3'd0);
	assign ld_data  = res;
	assign fb_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 2'd0;
			partial_q   <= 8'd0;
			in_col_q    <= 6'd0;
			out_col_q   <= 7'd0;
			row_count_q <= 8'd0;
		end else begin
			if (!fb_stall) begin
				valid_s1 <= fb_valid;
			end
			if (adv) begin
				phase_q   <= row_last ? 2'd0 : endph;
				partial_q <= partial_nx;
				in_col_q  <= row_last ? 6'd0 : in_col_q + 6'd1;
				out_col_q <= out_col_nx;
				if (row_last) begin
					row_count_q <= frame_row ? 8'd0 : row_count_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fb_valid && !fb_stall) begin
			fb_byte_s1 <= fb_byte;
		end
	end

endmodule

### rtl/mtp_burst.sv
module mtp_burst (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ld_valid,
	input  mtp_pkg::burst_t ld_data,
	output logic            free,
	output logic            pk_valid,
	input  logic            pk_stall,
	output logic [7:0]      packed_byte,
	output logic            row_end,
	output logic            frame_end,
	output logic            last
);
	import mtp_pkg::*;

	burst_t     data_q;
	logic [2:0] cnt_q;
	logic       take;

	assign pk_valid    = cnt_q != 3'd0;
	assign take        = pk_valid && !pk_stall;
	assign free        = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take);
	assign packed_byte = data_q.bytes[0];
	assign row_end     = data_q.row_end[0];
	assign frame_end   = data_q.frame_end[0];
	assign last        = cnt_q == 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (ld_valid) begin
			cnt_q <= ld_data.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// advance to the next packed byte on each taken transaction
	always_ff @(posedge clk) begin
		if (ld_valid) begin
			data_q <= ld_data;
		end else if (take) begin
			data_q.bytes     <= data_q.bytes >> 8;
			data_q.row_end   <= data_q.row_end >> 1;
			data_q.frame_end <= data_q.frame_end >> 1;
		end
	end

endmodule

### rtl/mono_to_three_pixel_packer.sv
// Mono to three-pixel packer.
// Input channel (fb_valid / fb_stall / fb_byte) takes one framebuffer byte per
// transaction, raster order, bit 0 leftmost. Output channel (pk_valid /
// pk_stall) delivers packed controller bytes, three pixels each, with
// row_end, frame_end and last (final byte caused by one input byte).
// Registers line_bytes, out_bytes_per_row and rows_per_frame sit on the
// APB port at 0x0, 0x4 and 0x8; write them only while the block is idle.
// An accepted byte is registered in the input stage, reduced there and
// loaded into the output register, from which its results are presented.
// An input byte yields zero to four results; the output register drains
// one per cycle while pk_stall is low. The next byte is reduced while the
// output register still drains, and a byte that yields nothing passes
// without loading the output register.
// Reset clears the pixel phase, partial byte and row/column counters, empties
// both stages and restores the register defaults. While pk_stall is high
// the current result holds; once the input register is blocked, fb_stall
// rises and backpressure reaches the sender.
`include "mono_to_three_pixel_packer_defines.svh"

module mono_to_three_pixel_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        fb_valid,
	output logic        fb_stall,
	input  logic [7:0]  fb_byte,
	output logic        pk_valid,
	input  logic        pk_stall,
	output logic [7:0]  packed_byte,
	output logic        row_end,
	output logic        frame_end,
	output logic        last
);
	import mtp_pkg::*;

	cfg_t   cfg;
	burst_t ld_data;
	logic   ld_valid;
	logic   burst_free;

	mtp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtp_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fb_valid   (fb_valid),
		.fb_stall   (fb_stall),
		.fb_byte    (fb_byte),
		.burst_free (burst_free),
		.ld_valid   (ld_valid),
		.ld_data    (ld_data)
	);

	mtp_burst u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld_valid    (ld_valid),
		.ld_data     (ld_data),
		.free        (burst_free),
		.pk_valid    (pk_valid),
		.pk_stall    (pk_stall),
		.packed_byte (packed_byte),
		.row_end     (row_end),
		.frame_end   (frame_end),
		.last        (last)
	);

	`MTP_ASSERT_IMP(a_load_when_free, ld_valid, burst_free, "burst overwritten while busy")
	`MTP_ASSERT_IMP(a_frame_on_row, pk_valid && frame_end, row_end, "frame_end without row_end")
	`MTP_ASSERT_IMP(a_row_end_last, pk_valid && row_end, last, "row_end before last result")
	`MTP_ASSERT_NXT(a_stall_keeps_valid, ld_valid, pk_valid, "loaded burst not presented")

endmodule
